[rtl/antialiased_line_stepper_macros.svh]
// assertion macros shared by the line stepper checker
// every property is sampled on clock and disabled while reset is high
`ifndef ANTIALIASED_LINE_STEPPER_MACROS_SVH
`define ANTIALIASED_LINE_STEPPER_MACROS_SVH

// plain property under the block clock
`define ALS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define ALS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/als_pkg.sv]
// shared types and codes for the antialiased line stepper
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package als_pkg;

   // request action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT_MINOR,
      ST_EMIT_MAJOR
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_seg;
      logic div_step;
      logic div_first;
      logic step_start;
      logic emit_minor;
      logic emit_major;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic active;
      logic wrap;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

[rtl/antialiased_line_stepper.sv]
// Antialiased line stepper. A load transaction (action 0) takes two endpoints and a color,
// orders them so x rises, picks the major axis from the inclusive spans and divides
// minor by major span into a Q(FRAC_BITS) slope with a restoring divider that makes
// one quotient bit per cycle, so a load holds req_ready low after it is accepted until
// the last slope bit is made. A step transaction (action 1) adds the slope to the
// fraction accumulator and produces one or two plot transactions: when the fraction
// wraps, first the pixel before the minor move at coverage one minus the fraction,
// then the pixel at coverage equal to the fraction, after which the major axis
// advances. The single result register hands out one plot per cycle while rsp_ready
// is high, and a low rsp_ready stalls the step; req_ready stays low until the step's
// last plot is in that register. A step with no line loaded is accepted and makes
// nothing. Coverage 2^FRAC_BITS means opaque; blending is done downstream.
// Depends on als_pkg, als_ctrl and als_datapath.
`timescale 1ns / 1ps
`default_nettype none

module antialiased_line_stepper #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   // request channel
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire                   req_action,
   input  wire  [COORD_BITS-1:0] req_x_start,
   input  wire  [COORD_BITS-1:0] req_y_start,
   input  wire  [COORD_BITS-1:0] req_x_end,
   input  wire  [COORD_BITS-1:0] req_y_end,
   input  wire  [7:0]            req_red_in,
   input  wire  [7:0]            req_green_in,
   input  wire  [7:0]            req_blue_in,
   // plot channel
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [FRAC_BITS:0]    rsp_coverage,
   output logic [7:0]            rsp_red_out,
   output logic [7:0]            rsp_green_out,
   output logic [7:0]            rsp_blue_out,
   output logic                  rsp_step_last,
   output logic                  rsp_line_done
);
   import als_pkg::*;

   // command and status between the state machine and the datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: idle accept, slope division, then up to two plot emits per step
   als_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd)
   );

   // segment registers, divider, accumulator and the plot output register
   als_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_x_start   (req_x_start),
      .req_y_start   (req_y_start),
      .req_x_end     (req_x_end),
      .req_y_end     (req_y_end),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_coverage  (rsp_coverage),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_step_last (rsp_step_last),
      .rsp_line_done (rsp_line_done)
   );

endmodule

`default_nettype wire

[rtl/als_ctrl.sv]
// controller state machine of the antialiased line stepper
// depends on als_pkg; drives the datapath through cmd_type, reads sts_type
`timescale 1ns / 1ps
`default_nettype none

module als_ctrl #(
   parameter int FRAC_BITS = 16
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  wire              req_action,
   input  als_pkg::sts_type sts,
   output als_pkg::cmd_type cmd
);
   import als_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   ctrl_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // ready is high here, so valid alone marks an accepted transaction
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACT_LOAD) begin
                  cmd.load_seg = 1'b1;
                  cnt_in       = '0;
                  state_in     = ST_DIVIDE;
               end else if (sts.active) begin
                  cmd.step_start = 1'b1;
                  state_in       = sts.wrap ? ST_EMIT_MINOR : ST_EMIT_MAJOR;
               end
            end
         end
         ST_DIVIDE: begin
            // one quotient bit per cycle, the first without a shift
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == '0);
            cnt_in        = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRAC_BITS)) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_MINOR: begin
            if (sts.out_free) begin
               cmd.emit_minor = 1'b1;
               state_in       = ST_EMIT_MAJOR;
            end
         end
         ST_EMIT_MAJOR: begin
            if (sts.out_free) begin
               cmd.emit_major = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/als_datapath.sv]
// datapath of the antialiased line stepper: segment setup, slope divider,
// fraction stepping and the result register; depends on als_pkg
`timescale 1ns / 1ps
`default_nettype none

module als_datapath #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  als_pkg::cmd_type        cmd,
   output als_pkg::sts_type        sts,
   input  wire  [COORD_BITS-1:0]   req_x_start,
   input  wire  [COORD_BITS-1:0]   req_y_start,
   input  wire  [COORD_BITS-1:0]   req_x_end,
   input  wire  [COORD_BITS-1:0]   req_y_end,
   input  wire  [7:0]              req_red_in,
   input  wire  [7:0]              req_green_in,
   input  wire  [7:0]              req_blue_in,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic [COORD_BITS-1:0]   rsp_pixel_x,
   output logic [COORD_BITS-1:0]   rsp_pixel_y,
   output logic [FRAC_BITS:0]      rsp_coverage,
   output logic [7:0]              rsp_red_out,
   output logic [7:0]              rsp_green_out,
   output logic [7:0]              rsp_blue_out,
   output logic                    rsp_step_last,
   output logic                    rsp_line_done
);
   import als_pkg::*;

   localparam int C = COORD_BITS;
   localparam int F = FRAC_BITS;
   localparam logic [F:0] FRAC_ONE = (F+1)'(1) << F;

   // segment state
   logic [C-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in, major_end_ff;
   logic         y_down_ff, steep_ff, active_ff, active_in, done_ff;
   logic [F-1:0] frac_ff;
   logic [F:0]   slope_ff;
   logic [C:0]   rem_ff, den_ff;
   logic [7:0]   red_ff, green_ff, blue_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   // setup
   logic         swap, y_down_new, steep_new;
   logic [C-1:0] xa, ya, xb, yb;
   logic [C:0]   span_x, span_y;
   // divider and stepping
   logic [C:0]   rem_t;
   logic         rem_ge;
   logic [F:0]   sum;
   logic [C-1:0] major_now;

   always_comb begin
      swap       = req_x_end < req_x_start;
      xa         = swap ? req_x_end : req_x_start;
      ya         = swap ? req_y_end : req_y_start;
      xb         = swap ? req_x_start : req_x_end;
      yb         = swap ? req_y_start : req_y_end;
      span_x     = (C+1)'(xb - xa) + (C+1)'(1);
      span_y     = (ya < yb) ? (C+1)'(yb - ya) + (C+1)'(1)
                             : (C+1)'(ya - yb) + (C+1)'(1);
      y_down_new = !(ya < yb);
      steep_new  = span_x < span_y;
   end

   always_comb begin
      rem_t     = cmd.div_first ? rem_ff : {rem_ff[C-1:0], 1'b0};
      rem_ge    = rem_t >= den_ff;
      sum       = {1'b0, frac_ff} + slope_ff;
      major_now = steep_ff ? cur_y_ff : cur_x_ff;
   end

   // pixel moves
   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      active_in = active_ff;
      if (cmd.load_seg) begin
         cur_x_in  = xa;
         cur_y_in  = ya;
         active_in = 1'b1;
      end else if (cmd.emit_minor) begin
         if (steep_ff) begin
            cur_x_in = cur_x_ff + C'(1);
         end else if (y_down_ff) begin
            cur_y_in = cur_y_ff - C'(1);
         end else begin
            cur_y_in = cur_y_ff + C'(1);
         end
      end else if (cmd.emit_major) begin
         if (!steep_ff) begin
            cur_x_in = cur_x_ff + C'(1);
         end else if (y_down_ff) begin
            cur_y_in = cur_y_ff - C'(1);
         end else begin
            cur_y_in = cur_y_ff + C'(1);
         end
         if (done_ff) begin
            active_in = 1'b0;
         end
      end
   end

   assign rsp_valid_in = (cmd.emit_minor || cmd.emit_major) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      if (cmd.load_seg) begin
         y_down_ff    <= y_down_new;
         steep_ff     <= steep_new;
         major_end_ff <= steep_new ? yb : xb;
         rem_ff       <= steep_new ? span_x : span_y;
         den_ff       <= steep_new ? span_y : span_x;
         slope_ff     <= '0;
         frac_ff      <= '0;
         red_ff       <= req_red_in;
         green_ff     <= req_green_in;
         blue_ff      <= req_blue_in;
      end
      if (cmd.div_step) begin
         rem_ff   <= rem_ge ? rem_t - den_ff : rem_t;
         slope_ff <= {slope_ff[F-1:0], rem_ge};
      end
      if (cmd.step_start) begin
         frac_ff <= sum[F-1:0];
         done_ff <= (major_now == major_end_ff);
      end
      if (cmd.emit_minor || cmd.emit_major) begin
         rsp_pixel_x   <= cur_x_ff;
         rsp_pixel_y   <= cur_y_ff;
         rsp_coverage  <= cmd.emit_minor ? FRAC_ONE - {1'b0, frac_ff} : {1'b0, frac_ff};
         rsp_red_out   <= red_ff;
         rsp_green_out <= green_ff;
         rsp_blue_out  <= blue_ff;
         rsp_step_last <= cmd.emit_major;
         rsp_line_done <= done_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign sts.active   = active_ff;
   assign sts.wrap     = sum[F];
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

[rtl/als_checker.sv]
// port-level checker for the antialiased line stepper, bound to the top level
// depends on als_pkg and antialiased_line_stepper_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "antialiased_line_stepper_macros.svh"

module als_checker #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_ready,
   input wire                  req_action,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input wire [COORD_BITS-1:0] rsp_pixel_x,
   input wire [COORD_BITS-1:0] rsp_pixel_y,
   input wire [FRAC_BITS:0]    rsp_coverage,
   input wire                  rsp_step_last,
   input wire                  rsp_line_done
);
   import als_pkg::*;

   localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   // a held plot keeps its payload
   `ALS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_coverage) && $stable(rsp_step_last) && $stable(rsp_line_done), "plot changed while stalled")
   // coverage never exceeds opaque
   `ALS_ASSERT(a_cov_range, !rsp_valid || rsp_coverage <= FRAC_ONE, "coverage above one")
   // the plot before a minor move always has some coverage
   `ALS_ASSERT(a_minor_cov, !(rsp_valid && !rsp_step_last) || rsp_coverage != '0, "minor plot with zero coverage")
   // a load keeps the request side closed while the slope divides
   `ALS_ASSERT_NEXT(a_load_busy, req_valid && req_ready && req_action == ACT_LOAD, !req_ready, "request taken during slope division")

endmodule

bind antialiased_line_stepper als_checker #(
   .COORD_BITS (COORD_BITS),
   .FRAC_BITS  (FRAC_BITS)
) u_als_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_action    (req_action),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_pixel_x   (rsp_pixel_x),
   .rsp_pixel_y   (rsp_pixel_y),
   .rsp_coverage  (rsp_coverage),
   .rsp_step_last (rsp_step_last),
   .rsp_line_done (rsp_line_done)
);

`default_nettype wire
